@@ hdl/qbts_pkg.sv @@
package qbts_pkg;

	localparam int unsigned PeriodW = 24;
	localparam int unsigned TicksW  = 16;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_ON   = 2'd1;
	localparam logic [1:0] PH_OFF  = 2'd2;

	typedef enum logic {
		OP_ENQ  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef struct packed {
		logic [PeriodW-1:0] period;
		logic [PeriodW-1:0] pulse;
		logic [TicksW-1:0]  on_ticks;
		logic [TicksW-1:0]  off_ticks;
	} beep_t;

	typedef struct packed {
		op_t   op;
		beep_t beep;
	} cmd_t;

	function automatic logic [TicksW-1:0] at_least_one(input logic [TicksW-1:0] d);
		at_least_one = (d == '0) ? TicksW'(1) : d;
	endfunction

endpackage

@@ hdl/qbts_ram.sv @@
module qbts_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/qbts_front.sv @@
module qbts_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    mode,
	input  logic [23:0]             tone_period,
	input  logic [23:0]             tone_pulse,
	input  logic [15:0]             on_ticks,
	input  logic [15:0]             off_ticks,
	output logic                    cmd_valid,
	output qbts_pkg::cmd_t          cmd,
	input  logic                    cmd_take
);

	qbts_pkg::cmd_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;
	qbts_pkg::cmd_t in_cmd;

	always_comb begin
		in_cmd.op             = qbts_pkg::op_t'(mode);
		in_cmd.beep.period    = tone_period;
		in_cmd.beep.pulse     = tone_pulse;
		in_cmd.beep.on_ticks  = on_ticks;
		in_cmd.beep.off_ticks = off_ticks;
	end

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ hdl/qbts_back.sv @@
module qbts_back #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	input  qbts_pkg::cmd_t                     cmd,
	output logic                               cmd_take,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [23:0]                        pwm_period,
	output logic [23:0]                        pwm_pulse,
	output logic [1:0]                         player_phase,
	output logic                               status,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_level
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_EXEC  = 2'b01,
		S_FETCH = 2'b10
	} st_t;

	st_t          st_q, st_nxt;
	logic [AW-1:0] head_q, head_nxt;
	logic [AW-1:0] tail_q, tail_nxt;
	logic [CW-1:0] count_q, count_nxt;
	logic [1:0]    phase_q, phase_nxt;
	logic [15:0]   ticks_q, ticks_nxt;
	logic [15:0]   gap_q, gap_nxt;
	logic [23:0]   per_q, per_nxt;
	logic [23:0]   pul_q, pul_nxt;
	logic          stat_nxt;
	logic          load_out;
	logic          out_valid_q;
	logic          out_free;
	logic          ram_we;
	qbts_pkg::beep_t rd_beep;
	logic [$bits(qbts_pkg::beep_t)-1:0] rd_raw;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
		wrap_inc = (a == AW'(QUEUE_DEPTH - 1)) ? '0 : a + AW'(1);
	endfunction

	qbts_ram #(
		.WIDTH($bits(qbts_pkg::beep_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (cmd.beep),
		.raddr (head_q),
		.rdata (rd_raw)
	);

	assign rd_beep  = qbts_pkg::beep_t'(rd_raw);
	assign out_free = !out_valid_q || !out_stall;
	assign cmd_take = (st_q == S_EXEC) && cmd_valid && out_free;
	assign out_valid = out_valid_q;

	always_comb begin
		st_nxt    = st_q;
		head_nxt  = head_q;
		tail_nxt  = tail_q;
		count_nxt = count_q;
		phase_nxt = phase_q;
		ticks_nxt = ticks_q;
		gap_nxt   = gap_q;
		per_nxt   = per_q;
		pul_nxt   = pul_q;
		stat_nxt  = 1'b0;
		load_out  = 1'b0;
		ram_we    = 1'b0;
		case (st_q)
			S_EXEC: begin
				if (cmd_take) begin
					load_out = 1'b1;
					if (cmd.op == qbts_pkg::OP_ENQ) begin
						if (count_q == CW'(QUEUE_DEPTH)) begin
							stat_nxt = 1'b1;
						end else begin
							ram_we    = 1'b1;
							tail_nxt  = wrap_inc(tail_q);
							count_nxt = count_q + CW'(1);
							if (phase_q == qbts_pkg::PH_IDLE) begin
								// empty and idle: the new beep is the head, start it directly
								per_nxt   = cmd.beep.period;
								pul_nxt   = cmd.beep.pulse;
								ticks_nxt = qbts_pkg::at_least_one(cmd.beep.on_ticks);
								gap_nxt   = qbts_pkg::at_least_one(cmd.beep.off_ticks);
								phase_nxt = qbts_pkg::PH_ON;
							end
						end
					end else if (phase_q == qbts_pkg::PH_ON) begin
						if (ticks_q <= 16'd1) begin
							head_nxt  = wrap_inc(head_q);
							if (count_q != '0) count_nxt = count_q - CW'(1);
							per_nxt   = '0;
							pul_nxt   = '0;
							ticks_nxt = gap_q;
							phase_nxt = qbts_pkg::PH_OFF;
						end else begin
							ticks_nxt = ticks_q - 16'd1;
						end
					end else if (phase_q == qbts_pkg::PH_OFF) begin
						if (ticks_q <= 16'd1) begin
							if (count_q == '0) begin
								phase_nxt = qbts_pkg::PH_IDLE;
								per_nxt   = '0;
								pul_nxt   = '0;
								ticks_nxt = '0;
							end else begin
								// head entry comes out of the RAM next cycle
								load_out = 1'b0;
								st_nxt   = S_FETCH;
							end
						end else begin
							ticks_nxt = ticks_q - 16'd1;
						end
					end
				end
			end
			S_FETCH: begin
				load_out  = 1'b1;
				per_nxt   = rd_beep.period;
				pul_nxt   = rd_beep.pulse;
				ticks_nxt = qbts_pkg::at_least_one(rd_beep.on_ticks);
				gap_nxt   = qbts_pkg::at_least_one(rd_beep.off_ticks);
				phase_nxt = qbts_pkg::PH_ON;
				st_nxt    = S_EXEC;
			end
			default: begin
				st_nxt = S_EXEC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_EXEC;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			phase_q     <= qbts_pkg::PH_IDLE;
			ticks_q     <= '0;
			gap_q       <= '0;
			per_q       <= '0;
			pul_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q    <= st_nxt;
			head_q  <= head_nxt;
			tail_q  <= tail_nxt;
			count_q <= count_nxt;
			phase_q <= phase_nxt;
			ticks_q <= ticks_nxt;
			gap_q   <= gap_nxt;
			per_q   <= per_nxt;
			pul_q   <= pul_nxt;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pwm_period   <= per_nxt;
			pwm_pulse    <= pul_nxt;
			player_phase <= phase_nxt;
			status       <= stat_nxt;
			queue_level  <= count_nxt;
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH)) else $error("queue count above depth");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == qbts_pkg::PH_IDLE) |-> (count_q == '0))
		else $error("idle with beeps queued");
	a_on_held: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == qbts_pkg::PH_ON) |-> (count_q != '0))
		else $error("tone on without a held beep");
	a_fetch_once: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FETCH) |=> (st_q == S_EXEC && out_valid_q))
		else $error("fetch did not produce a result");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled result lost");

endmodule

@@ hdl/queued_beep_tone_sequencer_core.sv @@
// Beep sequencer: enqueue transactions (mode 0) push a beep into a QUEUE_DEPTH-entry
// RAM queue, tick transactions (mode 1) advance the on/off timing; every input
// transaction yields exactly one result with the PWM setting, phase, drop status and
// queue level after it. A two-entry command queue decouples input acceptance from
// execution. A tick that ends an off gap while beeps are waiting goes through an extra
// fetch state, because the next head beep is read from the registered-read queue RAM.
module queued_beep_tone_sequencer_core #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               mode,
	input  logic [23:0]                        tone_period,
	input  logic [23:0]                        tone_pulse,
	input  logic [15:0]                        on_ticks,
	input  logic [15:0]                        off_ticks,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [23:0]                        pwm_period,
	output logic [23:0]                        pwm_pulse,
	output logic [1:0]                         player_phase,
	output logic                               status,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_level
);

	logic           cmd_valid;
	logic           cmd_take;
	qbts_pkg::cmd_t cmd;

	qbts_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.tone_period (tone_period),
		.tone_pulse  (tone_pulse),
		.on_ticks    (on_ticks),
		.off_ticks   (off_ticks),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_take    (cmd_take)
	);

	qbts_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_take     (cmd_take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pwm_period   (pwm_period),
		.pwm_pulse    (pwm_pulse),
		.player_phase (player_phase),
		.status       (status),
		.queue_level  (queue_level)
	);

endmodule

@@ test/qbts_checker.sv @@
module qbts_checker #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned LevelW      = $clog2(QUEUE_DEPTH+1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              mode,
	input  logic [23:0]       tone_period,
	input  logic [23:0]       tone_pulse,
	input  logic [15:0]       on_ticks,
	input  logic [15:0]       off_ticks,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [23:0]       pwm_period,
	input  logic [23:0]       pwm_pulse,
	input  logic [1:0]        player_phase,
	input  logic              status,
	input  logic [LevelW-1:0] queue_level,
	output int unsigned       mismatch_count,
	output int unsigned       reports_pending
);

	typedef struct packed {
		logic [23:0]       period;
		logic [23:0]       pulse;
		logic [1:0]        phase;
		logic              status;
		logic [LevelW-1:0] level;
	} tone_report_t;

	qbts_pkg::beep_t beep_store [QUEUE_DEPTH];
	int unsigned     head_slot;
	int unsigned     beeps_held;
	logic [1:0]      play_phase;
	logic [15:0]     ticks_left;
	logic [23:0]     drive_period;
	logic [23:0]     drive_pulse;
	tone_report_t    expected_reports [$];

	// start the beep at the head, or fall silent and idle when nothing is held
	task automatic sound_head_beep();
		if (beeps_held == 0) begin
			play_phase   = qbts_pkg::PH_IDLE;
			drive_period = '0;
			drive_pulse  = '0;
			ticks_left   = '0;
		end else begin
			drive_period = beep_store[head_slot].period;
			drive_pulse  = beep_store[head_slot].pulse;
			ticks_left   = (beep_store[head_slot].on_ticks == '0) ? 16'd1 :
				beep_store[head_slot].on_ticks;
			play_phase   = qbts_pkg::PH_ON;
		end
	endtask

	task automatic advance_player(input qbts_pkg::op_t op, input qbts_pkg::beep_t beep,
		output tone_report_t rep);
		logic dropped;
		dropped = 1'b0;
		if (op == qbts_pkg::OP_ENQ) begin
			if (beeps_held >= QUEUE_DEPTH) begin
				dropped = 1'b1;
			end else begin
				beep_store[(head_slot + beeps_held) % QUEUE_DEPTH] = beep;
				beeps_held++;
				if (play_phase == qbts_pkg::PH_IDLE)
					sound_head_beep();
			end
		end else if (play_phase == qbts_pkg::PH_ON) begin
			if (ticks_left <= 16'd1) begin
				// tone done: pop the head and run its silent gap
				ticks_left   = (beep_store[head_slot].off_ticks == '0) ? 16'd1 :
					beep_store[head_slot].off_ticks;
				head_slot    = (head_slot + 1) % QUEUE_DEPTH;
				beeps_held--;
				drive_period = '0;
				drive_pulse  = '0;
				play_phase   = qbts_pkg::PH_OFF;
			end else begin
				ticks_left--;
			end
		end else if (play_phase == qbts_pkg::PH_OFF) begin
			if (ticks_left <= 16'd1)
				sound_head_beep();
			else
				ticks_left--;
		end
		rep.period = drive_period;
		rep.pulse  = drive_pulse;
		rep.phase  = play_phase;
		rep.status = dropped;
		rep.level  = LevelW'(beeps_held);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_channels
		tone_report_t    want;
		tone_report_t    seen;
		qbts_pkg::beep_t pushed;
		if (!arst_n) begin
			head_slot       = 0;
			beeps_held      = 0;
			play_phase      = qbts_pkg::PH_IDLE;
			ticks_left      = '0;
			drive_period    = '0;
			drive_pulse     = '0;
			mismatch_count  = 0;
			reports_pending = 0;
			expected_reports.delete();
		end else begin
			if (out_valid && !out_stall) begin
				seen = '{pwm_period, pwm_pulse, player_phase, status, queue_level};
				if (expected_reports.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"%0t: result with none expected: period %h pulse %h",
							" phase %0d status %0d level %0d"},
							$time, seen.period, seen.pulse, seen.phase, seen.status,
							seen.level);
				end else begin
					want = expected_reports.pop_front();
					if (seen !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"%0t: mismatch exp/act: period %h/%h pulse %h/%h",
								" phase %0d/%0d status %0d/%0d level %0d/%0d"},
								$time, want.period, seen.period, want.pulse, seen.pulse,
								want.phase, seen.phase, want.status, seen.status,
								want.level, seen.level);
					end
				end
			end
			if (in_valid && !in_stall) begin
				pushed = '{tone_period, tone_pulse, on_ticks, off_ticks};
				advance_player(qbts_pkg::op_t'(mode), pushed, want);
				expected_reports.push_back(want);
			end
			reports_pending = expected_reports.size();
		end
	end

endmodule

@@ test/tb_queued_beep_tone_sequencer_core.sv @@
module tb_queued_beep_tone_sequencer_core;

	localparam int unsigned QUEUE_DEPTH = 16;
	localparam int unsigned LevelW      = $clog2(QUEUE_DEPTH+1);
	localparam int unsigned RandomItems = 900;
	localparam int unsigned QuietLimit  = 5000;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              mode;
	logic [23:0]       tone_period;
	logic [23:0]       tone_pulse;
	logic [15:0]       on_ticks;
	logic [15:0]       off_ticks;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [23:0]       pwm_period;
	logic [23:0]       pwm_pulse;
	logic [1:0]        player_phase;
	logic              status;
	logic [LevelW-1:0] queue_level;

	int unsigned mismatch_count;
	int unsigned reports_pending;
	int unsigned quiet_cycles = 0;
	int unsigned stall_pct    = 0;
	int unsigned stall_left   = 0;
	int unsigned burst_left   = 1;

	queued_beep_tone_sequencer_core #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dut (.*);

	qbts_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: stall density is redrawn from four levels, sometimes none at all
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_left = $urandom_range(16, 96);
			case ($urandom_range(3))
				0: stall_pct = 0;
				1: stall_pct = 30;
				2: stall_pct = 60;
				default: stall_pct = 85;
			endcase
		end
		stall_left--;
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// one transaction, then a random gap when the current burst runs out
	task automatic put_item(input qbts_pkg::op_t op, input logic [23:0] per,
		input logic [23:0] pul, input logic [15:0] on_t, input logic [15:0] off_t);
		int unsigned gap;
		in_valid    <= 1'b1;
		mode        <= op;
		tone_period <= per;
		tone_pulse  <= pul;
		on_ticks    <= on_t;
		off_ticks   <= off_t;
		do @(posedge clk); while (in_stall);
		burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(99) < 30) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic logic [15:0] pick_ticks();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return 16'($urandom_range(0, 3));
		else if (r < 95)
			return 16'($urandom_range(4, 24));
		return 16'($urandom_range(25, 200));
	endfunction

	initial begin
		int unsigned sent;
		int unsigned enq_pct;
		int unsigned seg_len;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		mode        = qbts_pkg::OP_TICK;
		tone_period = '0;
		tone_pulse  = '0;
		on_ticks    = '0;
		off_ticks   = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick while idle, fields ignored
		put_item(qbts_pkg::OP_TICK, '1, '1, '1, '1);
		// zero durations last one tick each
		put_item(qbts_pkg::OP_ENQ, 24'hFFFFFF, 24'h000000, 16'd0, 16'd0);
		put_item(qbts_pkg::OP_TICK, '0, '0, '0, '0);
		put_item(qbts_pkg::OP_TICK, '0, '0, '0, '0);
		// second beep queued behind a running one, started when the gap ends
		put_item(qbts_pkg::OP_ENQ, 24'h000000, 24'hFFFFFF, 16'd1, 16'd2);
		put_item(qbts_pkg::OP_ENQ, 24'hAAAAAA, 24'h555555, 16'd3, 16'd0);
		repeat (3)
			put_item(qbts_pkg::OP_TICK, 24'($urandom), 24'($urandom), 16'($urandom),
				16'($urandom));
		// fill the queue, one long beep inside, then a dropped enqueue
		for (int i = 0; i < 15; i++)
			put_item(qbts_pkg::OP_ENQ, 24'($urandom), 24'($urandom),
				(i == 7) ? 16'd300 : 16'($urandom_range(0, 3)),
				16'($urandom_range(0, 3)));
		put_item(qbts_pkg::OP_ENQ, '1, '1, 16'hFFFF, 16'hFFFF);

		sent = 0;
		while (sent < RandomItems) begin
			case ($urandom_range(3))
				0: enq_pct = 10;
				1: enq_pct = 35;
				2: enq_pct = 60;
				default: enq_pct = 90;
			endcase
			seg_len = $urandom_range(20, 60);
			for (int i = 0; i < seg_len; i++) begin
				if ($urandom_range(99) < enq_pct)
					put_item(qbts_pkg::OP_ENQ, 24'($urandom), 24'($urandom),
						pick_ticks(), pick_ticks());
				else
					put_item(qbts_pkg::OP_TICK, 24'($urandom), 24'($urandom),
						16'($urandom), 16'($urandom));
			end
			sent += seg_len;
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (reports_pending == 0);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
